// ===== hdl/ctwa_pkg.sv =====
// Shared types and constants of the complex trailing-window average unit.
package ctwa_pkg;

    localparam int SAMPLE_W = 24;
    localparam int INDEX_W  = 10;
    localparam int WINDOW_W = 6;
    localparam int COUNT_W  = 6;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Register index, taken from paddr[2].
    localparam logic REG_FILTER_ENABLE = 1'b0;
    localparam logic REG_WINDOW_LENGTH = 1'b1;

    typedef struct packed {
        logic                filter_enable;
        logic [WINDOW_W-1:0] window_length;
    } t_cfg;

    // One classified request, as it travels from the front to the back.
    typedef struct packed {
        logic                       ch;
        logic [INDEX_W-1:0]         idx;
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic                       filt;
        logic [WINDOW_W-1:0]        nb;
        logic                       wr_ok;
    } t_cmd;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] avg_re;
        logic signed [SAMPLE_W-1:0] avg_im;
        logic [COUNT_W-1:0]         points_used;
    } t_res;

endpackage

// ===== hdl/complex_trailing_window_average_unit.sv =====
// Top level of the complex trailing-window average unit.
//
//  Channel    Handshake                        Payload
//  ---------  -------------------------------  ---------------------------------------
//  input      push / full                      i_channel, i_point_index, i_sample_re/im
//  result     pop / empty                      o_avg_re, o_avg_im, o_points_used
//  config     psel, penable, pwrite / pready   paddr, pwdata, prdata
//
// After reset the store is swept to zero, one entry a cycle, with full held high and
// configuration writes still taken. With filtering on, a request reads up to 31 earlier
// neighbors with the defaults through the single store read port, and its sums, which are
// SUM_W = 24 + log2(MAX_WINDOW) bits wide, go through the two-bit-a-cycle divider.
// A four-entry request queue and a two-entry result queue let the sides stall apart.
module complex_trailing_window_average_unit #(
    parameter int POINTS     = 1024,
    parameter int MAX_WINDOW = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input queue side.
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 i_channel,
    input  logic [ctwa_pkg::INDEX_W-1:0]         i_point_index,
    input  logic signed [ctwa_pkg::SAMPLE_W-1:0] i_sample_re,
    input  logic signed [ctwa_pkg::SAMPLE_W-1:0] i_sample_im,
    // Result queue side.
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [ctwa_pkg::SAMPLE_W-1:0] o_avg_re,
    output logic signed [ctwa_pkg::SAMPLE_W-1:0] o_avg_im,
    output logic [ctwa_pkg::COUNT_W-1:0]         o_points_used,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ctwa_pkg::PADDR_W-1:0]         paddr,
    input  logic [ctwa_pkg::PDATA_W-1:0]         pwdata,
    output logic [ctwa_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);

    import ctwa_pkg::*;

    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;
    localparam int CMD_W     = $bits(t_cmd);
    localparam int RES_W     = $bits(t_res);

    logic                r_filter_enable;
    logic [WINDOW_W-1:0] r_window_length;
    t_cfg                cfg;
    logic                cfg_wr;

    logic                cmd_push;
    logic                cmd_full;
    logic                cmd_empty;
    logic                cmd_pop;
    t_cmd                cmd_in;
    t_cmd                cmd_head;
    logic [CMD_W-1:0]    cmd_rdata;

    logic                res_push;
    logic                res_full;
    t_res                res_in;
    t_res                res_head;
    logic [RES_W-1:0]    res_rdata;
    logic                clearing;

    // The port never inserts wait states; a write lands on the access cycle.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_enable <= 1'b0;
            r_window_length <= WINDOW_W'(8);
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_FILTER_ENABLE: r_filter_enable <= pwdata[0];
                REG_WINDOW_LENGTH: r_window_length <= pwdata[WINDOW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FILTER_ENABLE: prdata = PDATA_W'(r_filter_enable);
            REG_WINDOW_LENGTH: prdata = PDATA_W'(r_window_length);
            default:           prdata = '0;
        endcase
    end

    assign cfg.filter_enable = r_filter_enable;
    assign cfg.window_length = r_window_length;

    // The front end classifies each point as it is taken: window size after
    // saturation, how many earlier neighbors exist, and whether the index
    // lies inside the store.
    ctwa_front #(
        .POINTS     (POINTS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .i_push        (push),
        .o_full        (full),
        .i_channel     (i_channel),
        .i_point_index (i_point_index),
        .i_sample_re   (i_sample_re),
        .i_sample_im   (i_sample_im),
        .i_cfg         (cfg),
        .i_clearing    (clearing),
        .i_cmd_full    (cmd_full),
        .o_cmd_push    (cmd_push),
        .o_cmd         (cmd_in)
    );

    ctwa_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_rdata),
        .o_empty (cmd_empty)
    );

    assign cmd_head = cmd_rdata;

    // The back end handles one request at a time, so the store write of a
    // point always precedes the window reads of the next one.
    ctwa_back #(
        .POINTS     (POINTS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_head),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .o_clearing  (clearing)
    );

    ctwa_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_rdata),
        .o_empty (empty)
    );

    assign res_head      = res_rdata;
    assign o_avg_re      = res_head.avg_re;
    assign o_avg_im      = res_head.avg_im;
    assign o_points_used = res_head.points_used;

    // No point may be taken while the store is still being cleared.
    a_clear_blocks_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) clearing |-> full
    ) else $error("input accepted during store clear");

    // The back end only hands over a result when the result queue has room.
    a_res_no_overflow: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) res_push |-> !res_full
    ) else $error("result queue overflow");

    // The front end only queues a request when the request queue has room.
    a_cmd_no_overflow: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) cmd_push |-> !cmd_full
    ) else $error("request queue overflow");

    // The back end never takes a request from an empty queue.
    a_cmd_pop_valid: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) cmd_pop |-> !cmd_empty
    ) else $error("request taken from empty queue");

endmodule

// ===== hdl/ctwa_fifo.sv =====
// Small register-based first-in first-out queue.
module ctwa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (pop_ok) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== hdl/ctwa_front.sv =====
// Front end: accepts sweep points and classifies them into back-end requests.
module ctwa_front #(
    parameter int POINTS     = 1024,
    parameter int MAX_WINDOW = 32
) (
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic                                 i_channel,
    input  logic [ctwa_pkg::INDEX_W-1:0]         i_point_index,
    input  logic signed [ctwa_pkg::SAMPLE_W-1:0] i_sample_re,
    input  logic signed [ctwa_pkg::SAMPLE_W-1:0] i_sample_im,
    input  ctwa_pkg::t_cfg                       i_cfg,
    input  logic                                 i_clearing,
    input  logic                                 i_cmd_full,
    output logic                                 o_cmd_push,
    output ctwa_pkg::t_cmd                       o_cmd
);

    import ctwa_pkg::*;

    logic [WINDOW_W-1:0] win;
    logic [WINDOW_W-1:0] win_m1;

    // Nothing is taken while the store is being cleared.
    assign o_full     = i_cmd_full || i_clearing;
    assign o_cmd_push = i_push && !o_full;

    always_comb begin
        // A zero window means the current point alone; long windows saturate.
        if (i_cfg.window_length == '0) begin
            win = WINDOW_W'(1);
        end else if (32'(i_cfg.window_length) > MAX_WINDOW) begin
            win = WINDOW_W'(MAX_WINDOW);
        end else begin
            win = i_cfg.window_length;
        end
        win_m1 = win - WINDOW_W'(1);

        o_cmd.ch   = i_channel;
        o_cmd.idx  = i_point_index;
        o_cmd.re   = i_sample_re;
        o_cmd.im   = i_sample_im;
        o_cmd.filt = i_cfg.filter_enable;
        // Neighbors below index zero do not exist near the start of the sweep.
        o_cmd.nb   = (INDEX_W'(win_m1) <= i_point_index) ? win_m1
                                                         : WINDOW_W'(i_point_index);
        o_cmd.wr_ok = (32'(i_point_index) < POINTS);
    end

endmodule

// ===== hdl/ctwa_back.sv =====
// Back end: sample store, window accumulation and the iterative divider.
module ctwa_back #(
    parameter int POINTS     = 1024,
    parameter int MAX_WINDOW = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ctwa_pkg::t_cmd i_cmd,
    input  logic           i_cmd_empty,
    output logic           o_cmd_pop,
    input  logic           i_res_full,
    output logic           o_res_push,
    output ctwa_pkg::t_res o_res,
    output logic           o_clearing
);

    import ctwa_pkg::*;

    localparam int MW     = $clog2(2 * POINTS);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int DV_W   = SUM_W + (SUM_W % 2);
    localparam int STEP_W = $clog2(DV_W / 2 + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DINIT = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_SIGN  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2*SAMPLE_W-1:0]      r_mem [2*POINTS];
    logic [2*SAMPLE_W-1:0]      r_rd_data;
    logic [2:0]                 r_state;
    logic [MW-1:0]              r_clr_addr;
    t_cmd                       r_cmd;
    logic signed [SUM_W-1:0]    r_sum_re;
    logic signed [SUM_W-1:0]    r_sum_im;
    logic [CNT_W-1:0]           r_cnt;
    logic [WINDOW_W-1:0]        r_left;
    logic [INDEX_W-1:0]         r_k;
    logic                       r_pend;
    logic                       r_neg_re;
    logic                       r_neg_im;
    logic [DV_W-1:0]            r_dv_re;
    logic [DV_W-1:0]            r_dv_im;
    logic [CNT_W-1:0]           r_rem_re;
    logic [CNT_W-1:0]           r_rem_im;
    logic [STEP_W-1:0]          r_steps;
    logic signed [SAMPLE_W-1:0] r_avg_re;
    logic signed [SAMPLE_W-1:0] r_avg_im;

    logic [DV_W-1:0]            n_dv_re;
    logic [DV_W-1:0]            n_dv_im;
    logic [CNT_W-1:0]           n_rem_re;
    logic [CNT_W-1:0]           n_rem_im;
    logic [DV_W-1:0]            s1_dv_re;
    logic [DV_W-1:0]            s1_dv_im;
    logic [CNT_W-1:0]           s1_rem_re;
    logic [CNT_W-1:0]           s1_rem_im;

    logic                       k_ok;
    logic [MW-1:0]              rd_addr;
    logic                       wr_en;
    logic [MW-1:0]              wr_addr;
    logic [2*SAMPLE_W-1:0]      wr_data;
    logic signed [SAMPLE_W-1:0] rd_re;
    logic signed [SAMPLE_W-1:0] rd_im;
    logic signed [SUM_W-1:0]    abs_re;
    logic signed [SUM_W-1:0]    abs_im;
    logic [DV_W-1:0]            q_re;
    logic [DV_W-1:0]            q_im;

    function automatic logic [MW-1:0] addr_of(logic ch, logic [INDEX_W-1:0] k);
        addr_of = ch ? (MW'(POINTS) + MW'(k)) : MW'(k);
    endfunction

    // One restoring division step: brings in the next dividend bit at the
    // top and shifts the new quotient bit in at the bottom.
    function automatic logic [CNT_W+DV_W-1:0] div_step(
        logic [CNT_W-1:0] rem, logic [DV_W-1:0] dv, logic [CNT_W-1:0] d);
        logic [CNT_W:0]   sh;
        logic [CNT_W:0]   diff;
        logic [DV_W-1:0]  dv_n;
        logic [CNT_W-1:0] rem_n;
        sh   = {rem, dv[DV_W-1]};
        diff = sh - {1'b0, d};
        dv_n = {dv[DV_W-2:0], 1'b0};
        if (sh >= {1'b0, d}) begin
            rem_n   = diff[CNT_W-1:0];
            dv_n[0] = 1'b1;
        end else begin
            rem_n = sh[CNT_W-1:0];
        end
        div_step = {rem_n, dv_n};
    endfunction

    assign o_clearing = (r_state == S_CLEAR);
    assign o_cmd_pop  = (r_state == S_IDLE) && !i_cmd_empty;
    assign o_res_push = (r_state == S_DONE) && !i_res_full;

    assign o_res.avg_re      = r_avg_re;
    assign o_res.avg_im      = r_avg_im;
    assign o_res.points_used = COUNT_W'(r_cnt);

    assign rd_re = r_rd_data[2*SAMPLE_W-1:SAMPLE_W];
    assign rd_im = r_rd_data[SAMPLE_W-1:0];

    always_comb begin
        k_ok    = (32'(r_k) < POINTS);
        rd_addr = k_ok ? addr_of(r_cmd.ch, r_k) : '0;

        // The raw point goes into the store once its window has been read.
        wr_en   = o_clearing || (o_res_push && r_cmd.wr_ok);
        wr_addr = o_clearing ? r_clr_addr : addr_of(r_cmd.ch, r_cmd.idx);
        wr_data = o_clearing ? '0 : {r_cmd.re, r_cmd.im};

        abs_re = r_sum_re[SUM_W-1] ? -r_sum_re : r_sum_re;
        abs_im = r_sum_im[SUM_W-1] ? -r_sum_im : r_sum_im;

        {s1_rem_re, s1_dv_re} = div_step(r_rem_re, r_dv_re, r_cnt);
        {n_rem_re, n_dv_re}   = div_step(s1_rem_re, s1_dv_re, r_cnt);
        {s1_rem_im, s1_dv_im} = div_step(r_rem_im, r_dv_im, r_cnt);
        {n_rem_im, n_dv_im}   = div_step(s1_rem_im, s1_dv_im, r_cnt);

        q_re = r_neg_re ? (DV_W'(0) - r_dv_re) : r_dv_re;
        q_im = r_neg_im ? (DV_W'(0) - r_dv_im) : r_dv_im;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_pend     <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + MW'(1);
                    if (r_clr_addr == MW'(2 * POINTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_cmd    <= i_cmd;
                        r_sum_re <= SUM_W'(i_cmd.re);
                        r_sum_im <= SUM_W'(i_cmd.im);
                        r_avg_re <= i_cmd.re;
                        r_avg_im <= i_cmd.im;
                        r_cnt    <= CNT_W'(1);
                        r_left   <= i_cmd.nb;
                        r_k      <= i_cmd.idx - INDEX_W'(1);
                        r_pend   <= 1'b0;
                        if (i_cmd.filt && (i_cmd.nb != '0)) begin
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_READ: begin
                    // Reads are issued one per cycle; each one's data is registered and summed in the next cycle.
                    if (r_pend) begin
                        r_sum_re <= r_sum_re + SUM_W'(rd_re);
                        r_sum_im <= r_sum_im + SUM_W'(rd_im);
                        r_cnt    <= r_cnt + CNT_W'(1);
                    end
                    if (r_left != '0) begin
                        r_pend <= k_ok;
                        r_k    <= r_k - INDEX_W'(1);
                        r_left <= r_left - WINDOW_W'(1);
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_DINIT;
                    end
                end
                S_DINIT: begin
                    r_neg_re <= r_sum_re[SUM_W-1];
                    r_neg_im <= r_sum_im[SUM_W-1];
                    r_dv_re  <= DV_W'($unsigned(abs_re));
                    r_dv_im  <= DV_W'($unsigned(abs_im));
                    r_rem_re <= '0;
                    r_rem_im <= '0;
                    r_steps  <= STEP_W'(DV_W / 2);
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    r_dv_re  <= n_dv_re;
                    r_dv_im  <= n_dv_im;
                    r_rem_re <= n_rem_re;
                    r_rem_im <= n_rem_im;
                    r_steps  <= r_steps - STEP_W'(1);
                    if (r_steps == STEP_W'(1)) begin
                        r_state <= S_SIGN;
                    end
                end
                S_SIGN: begin
                    r_avg_re <= q_re[SAMPLE_W-1:0];
                    r_avg_im <= q_im[SAMPLE_W-1:0];
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
